/* rtl/core/ecgmd_pkg.sv */
// Package for the ECG median / decimate / limb-lead block.
// Constants, queue record type and back-end state type. No dependencies.
`default_nettype none
package ecgmd_pkg;
   localparam int CodeW    = 24;
   localparam int SumW     = 27;
   localparam int Taps     = 5;
   localparam int Chans    = 3;
   localparam int NumLeads = 7;
   localparam int UvW      = 22;
   localparam int NumW     = 30;   // signed lead numerators
   localparam int MagW     = 29;   // their magnitudes
   localparam int RecipW   = 22;

   localparam logic [CodeW-1:0]  CODE_ZERO       = 24'd6400000;
   localparam logic [NumW-1:0]   SUM_ZERO        = 30'd25600000;
   localparam logic [15:0]       PERSIST_RESET   = 16'd160;
   localparam logic [15:0]       RUN_MAX         = 16'hFFFF;
   localparam logic [RecipW-1:0] RECIP7          = 22'd2396745; // floor(2^24/7)
   localparam int                QUEUE_DEPTH_DEF = 2;

   // lead numerator slots
   localparam logic [2:0] LD_ONE   = 3'd0;
   localparam logic [2:0] LD_TWO   = 3'd1;
   localparam logic [2:0] LD_TWO_B = 3'd2;
   localparam logic [2:0] LD_THREE = 3'd3;
   localparam logic [2:0] LD_AVR   = 3'd4;
   localparam logic [2:0] LD_AVL   = 3'd5;
   localparam logic [2:0] LD_AVF   = 3'd6;
   localparam logic [2:0] LD_DONE  = 3'd7;

   typedef struct packed {
      logic [Chans-1:0][SumW-1:0] sums;
      logic [3:0]                 off;
      logic [1:0]                 alarm;
   } grp_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_NUM,
      BK_RUN,
      BK_SHOW
   } back_state_type;
endpackage
`default_nettype wire

/* rtl/core/ecgmd_if.sv */
// Channel interfaces for the ECG median / decimate block.
// No dependencies.
`default_nettype none
interface ecgmd_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] code_lead_one;
   logic [23:0] code_lead_two_a;
   logic [23:0] code_lead_two_b;
   logic [3:0]  electrode_off_bits;
   logic [1:0]  drive_alarm_bits;
   modport source (output valid, code_lead_one, code_lead_two_a, code_lead_two_b,
                   electrode_off_bits, drive_alarm_bits, input ready);
   modport sink   (input valid, code_lead_one, code_lead_two_a, code_lead_two_b,
                   electrode_off_bits, drive_alarm_bits, output ready);
endinterface

interface ecgmd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [21:0] lead_one_uv;
   logic signed [21:0] lead_two_uv;
   logic signed [21:0] lead_two_b_uv;
   logic signed [21:0] lead_three_uv;
   logic signed [21:0] augmented_right_uv;
   logic signed [21:0] augmented_left_uv;
   logic signed [21:0] augmented_foot_uv;
   logic [3:0]         off_status;
   logic [2:0]         off_status_legacy;
   logic               drive_fault;
   logic [31:0]        sample_number;
   modport source (output valid, lead_one_uv, lead_two_uv, lead_two_b_uv, lead_three_uv,
                   augmented_right_uv, augmented_left_uv, augmented_foot_uv, off_status,
                   off_status_legacy, drive_fault, sample_number, input ready);
   modport sink   (input valid, lead_one_uv, lead_two_uv, lead_two_b_uv, lead_three_uv,
                   augmented_right_uv, augmented_left_uv, augmented_foot_uv, off_status,
                   off_status_legacy, drive_fault, sample_number, output ready);
endinterface
`default_nettype wire

/* rtl/core/ecgmd_front.sv */
// Front end: median windows, 5-tap median, 4-sample group sums.
// Depends on ecgmd_pkg and ecgmd_req_if.
`default_nettype none
module ecgmd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   ecgmd_req_if.sink               req,
   output ecgmd_pkg::grp_type      push_data,
   output logic                    push_valid,
   input  wire logic               push_ready
);
   import ecgmd_pkg::*;

   logic [Taps-1:0][CodeW-1:0] win_ff [Chans];
   logic [Taps-1:0][CodeW-1:0] win_in [Chans];
   logic [2:0]                 slot_ff, slot_in;
   logic [1:0]                 phase_ff, phase_in;
   logic [SumW-1:0]            sum_ff [Chans];
   logic [SumW-1:0]            sum_in [Chans];
   logic [SumW-1:0]            sum_new [Chans];
   logic [CodeW-1:0]           codes [Chans];
   logic                       accept;

   // true middle of five: pick the element of stable rank two
   function automatic logic [CodeW-1:0] median5(input logic [Taps-1:0][CodeW-1:0] v);
      logic [2:0]       rank;
      logic [CodeW-1:0] m;
      m = v[0];
      for (int i = 0; i < Taps; i++) begin
         rank = 3'd0;
         for (int j = 0; j < Taps; j++) begin
            if ((j < i && v[j] <= v[i]) || (j > i && v[j] < v[i])) begin
               rank = rank + 3'd1;
            end
         end
         if (rank == 3'd2) begin
            m = v[i];
         end
      end
      return m;
   endfunction

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;

   always_comb begin
      codes[0] = req.code_lead_one;
      codes[1] = req.code_lead_two_a;
      codes[2] = req.code_lead_two_b;
      for (int c = 0; c < Chans; c++) begin
         for (int k = 0; k < Taps; k++) begin
            win_in[c][k] = (accept && slot_ff == 3'(k)) ? codes[c] : win_ff[c][k];
         end
         sum_new[c] = sum_ff[c] + SumW'(median5(win_in[c]));
         push_data.sums[c] = sum_new[c];
         if (accept) begin
            sum_in[c] = (phase_ff == 2'd3) ? '0 : sum_new[c];
         end else begin
            sum_in[c] = sum_ff[c];
         end
      end
      push_data.off   = req.electrode_off_bits;
      push_data.alarm = req.drive_alarm_bits;
      push_valid      = accept && (phase_ff == 2'd3);
      slot_in  = slot_ff;
      phase_in = phase_ff;
      if (accept) begin
         slot_in  = (slot_ff == 3'(Taps - 1)) ? 3'd0 : slot_ff + 3'd1;
         phase_in = phase_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < Chans; c++) begin
            win_ff[c] <= {Taps{CODE_ZERO}};
            sum_ff[c] <= '0;
         end
         slot_ff  <= 3'd0;
         phase_ff <= 2'd0;
      end else begin
         for (int c = 0; c < Chans; c++) begin
            win_ff[c] <= win_in[c];
            sum_ff[c] <= sum_in[c];
         end
         slot_ff  <= slot_in;
         phase_ff <= phase_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/core/ecgmd_queue.sv */
// Short queue of group records between front and back end.
// Depends on ecgmd_pkg.
`default_nettype none
module ecgmd_queue #(
   parameter int DEPTH = ecgmd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ecgmd_pkg::grp_type push_data,
   input  wire logic               push_valid,
   output logic                    push_ready,
   output ecgmd_pkg::grp_type      pop_data,
   output logic                    pop_valid,
   input  wire logic               pop_ready
);
   import ecgmd_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   grp_type         data_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign push_ready = (cnt_ff != CW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = data_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/core/ecgmd_back.sv */
// Back end: lead arithmetic, shared divide-by-112 unit (224 for augmented leads), alarm run, sequence.
// Depends on ecgmd_pkg and ecgmd_rsp_if.
`default_nettype none
module ecgmd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [15:0]        persist,
   input  wire ecgmd_pkg::grp_type pop_data,
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   ecgmd_rsp_if.source             rsp
);
   import ecgmd_pkg::*;

   localparam int AW = MagW - 4;           // magnitude over 16
   localparam int PW = AW + RecipW;
   localparam int QW = PW - 24;

   back_state_type      state_ff, state_in;
   logic signed [NumW-1:0] d_ff [Chans];
   logic signed [NumW-1:0] d_in [Chans];
   logic signed [NumW-1:0] num  [NumLeads];
   logic [MagW-1:0]     mag_ff [NumLeads];
   logic                sgn_ff [NumLeads];
   logic [2:0]          cnt_ff;
   logic [AW-1:0]       a_ff;
   logic [QW-1:0]       q0_ff;
   logic                psgn_ff, pvalid_ff;
   logic [2:0]          pidx_ff;
   logic signed [UvW-1:0] res_ff [NumLeads];
   logic [3:0]          off_ff;
   logic                fault_ff;
   logic [15:0]         run_ff, run_in;
   logic [31:0]         seq_ff, seq_out_ff;
   logic [AW-1:0]       a_sel;
   logic [PW-1:0]       prod;
   logic [AW:0]         rem;
   logic [QW-1:0]       q_fix;
   logic                take;

   assign take = (state_ff == BK_IDLE) && pop_valid;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (pop_valid) state_in = BK_NUM;
         BK_NUM:  state_in = BK_RUN;
         BK_RUN:  if (cnt_ff == LD_DONE) state_in = BK_SHOW;
         BK_SHOW: if (rsp.ready) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop_ready              = (state_ff == BK_IDLE);
      rsp.valid              = (state_ff == BK_SHOW);
      rsp.lead_one_uv        = res_ff[LD_ONE];
      rsp.lead_two_uv        = res_ff[LD_TWO];
      rsp.lead_two_b_uv      = res_ff[LD_TWO_B];
      rsp.lead_three_uv      = res_ff[LD_THREE];
      rsp.augmented_right_uv = res_ff[LD_AVR];
      rsp.augmented_left_uv  = res_ff[LD_AVL];
      rsp.augmented_foot_uv  = res_ff[LD_AVF];
      rsp.off_status         = off_ff;
      rsp.off_status_legacy  = off_ff[2:0];
      rsp.drive_fault        = fault_ff;
      rsp.sample_number      = seq_out_ff;
   end

   // d = 3 * (sum - zero)
   always_comb begin
      for (int c = 0; c < Chans; c++) begin
         d_in[c] = $signed(NumW'(pop_data.sums[c]) - SUM_ZERO);
         d_in[c] = d_in[c] + (d_in[c] <<< 1);
      end
      num[LD_ONE]   = d_ff[0];
      num[LD_TWO]   = d_ff[1];
      num[LD_TWO_B] = d_ff[2];
      num[LD_THREE] = d_ff[1] - d_ff[0];
      num[LD_AVR]   = -(d_ff[0] + d_ff[1]);
      num[LD_AVL]   = (d_ff[0] <<< 1) - d_ff[1];
      num[LD_AVF]   = (d_ff[1] <<< 1) - d_ff[0];
      run_in = (pop_data.alarm != 2'd0) ? ((run_ff == RUN_MAX) ? run_ff : run_ff + 16'd1)
                                        : 16'd0;
   end

   // x/112 = (x/16)/7; reciprocal estimate is low by at most one
   always_comb begin
      a_sel = mag_ff[cnt_ff][MagW-1:4];
      prod  = PW'(a_sel) * PW'(RECIP7);
      rem   = {1'b0, a_ff} - (AW + 1)'({q0_ff, 3'b000} - {3'b000, q0_ff});
      q_fix = q0_ff + ((rem >= (AW + 1)'(7)) ? QW'(1) : QW'(0));
      if (pidx_ff >= LD_AVR) begin
         q_fix = q_fix >> 1;                // over 224
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         for (int c = 0; c < Chans; c++) begin
            d_ff[c] <= d_in[c];
         end
         off_ff     <= pop_data.off;
         fault_ff   <= (run_in >= persist);
         seq_out_ff <= seq_ff;
      end
      if (state_ff == BK_NUM) begin
         for (int k = 0; k < NumLeads; k++) begin
            sgn_ff[k] <= num[k][NumW-1];
            mag_ff[k] <= num[k][NumW-1] ? MagW'(-num[k]) : MagW'(num[k]);
         end
      end
      a_ff    <= a_sel;
      q0_ff   <= prod[PW-1:24];
      psgn_ff <= sgn_ff[cnt_ff];
      pidx_ff <= cnt_ff;
      if (pvalid_ff) begin
         res_ff[pidx_ff] <= psgn_ff ? -$signed(q_fix[UvW-1:0]) : $signed(q_fix[UvW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         cnt_ff    <= 3'd0;
         pvalid_ff <= 1'b0;
         run_ff    <= 16'd0;
         seq_ff    <= 32'd0;
      end else begin
         state_ff  <= state_in;
         pvalid_ff <= (state_ff == BK_RUN) && (cnt_ff != LD_DONE);
         cnt_ff    <= (state_ff == BK_RUN) ? cnt_ff + 3'd1 : 3'd0;
         if (take) begin
            run_ff <= run_in;
            seq_ff <= seq_ff + 32'd1;
         end
      end
   end
endmodule
`default_nettype wire

/* rtl/core/ecg_median_decimate_leads.sv */
// Top level: ECG 5-tap median, 4:1 average decimate and limb-lead derivation.
// Depends on ecgmd_pkg, ecgmd_if, ecgmd_front, ecgmd_queue, ecgmd_back.
//
//   channel   dir   handshake       word
//   req_chan  in    valid/ready     three raw codes, off bits, alarm bits
//   rsp_chan  out   valid/ready     seven leads in uV, status, sample number
//   csr_*     in    write enable    fault_persist_count
//
// The front end takes one word per cycle while the queue is not full:
// window update, median and group sum in the accepting cycle. Every fourth
// word pushes a group record. The back end works on one group record at a
// time (load, numerators, pipelined divide by 112 or 224 through one
// multiplier, output) and takes no new record until its result is taken.
// Reset is synchronous, active high; medians restart from code 6400000.
// A stalled rsp_chan fills the queue, then req_chan ready drops.
`default_nettype none
module ecg_median_decimate_leads #(
   parameter int QUEUE_DEPTH = ecgmd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_en,
   input  wire logic [15:0] csr_write_data,
   ecgmd_req_if.sink        req_chan,
   ecgmd_rsp_if.source      rsp_chan
);
   import ecgmd_pkg::*;

   logic [15:0] persist_ff;
   grp_type     push_data, pop_data;
   logic        push_valid, push_ready, pop_valid, pop_ready;

   // persistence threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         persist_ff <= PERSIST_RESET;
      end else if (csr_write_en) begin
         persist_ff <= csr_write_data;
      end
   end

   ecgmd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   ecgmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   ecgmd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .persist   (persist_ff),
      .pop_data  (pop_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp       (rsp_chan)
   );
endmodule
`default_nettype wire

/* verif/tb_ecg_median_decimate_leads.sv */
// Testbench for ecg_median_decimate_leads: median, 4:1 decimate and lead math.
// Depends on ecgmd_pkg, ecgmd_if and the RTL top level; self-checking.
`default_nettype none
module tb_ecg_median_decimate_leads;
   timeunit 1ns;
   timeprecision 1ps;
   import ecgmd_pkg::*;

   typedef struct {
      logic [23:0] c1, c2, c3;
      logic [3:0]  off;
      logic [1:0]  alarm;
   } sample_type;

   typedef struct {
      logic signed [21:0] l1, l2, l2b, l3, avr, avl, avf;
      logic [3:0]  off;
      logic [2:0]  off3;
      logic        fault;
      logic [31:0] seq;
   } leads_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [15:0] csr_write_data = '0;

   ecgmd_req_if req_chan ();
   ecgmd_rsp_if rsp_chan ();

   ecg_median_decimate_leads dut (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always #5 clock = ~clock;

   // ---------------- predictor state ----------------
   logic [23:0] win [3][5];
   int unsigned slot, phase;
   longint      sums [3];
   int unsigned alarm_run;
   logic [15:0] persist;
   logic [31:0] seq_num;

   sample_type pending_words[$];
   leads_type  expected_leads[$];

   int  errors = 0;
   longint cycles = 0;
   bit  rx_hold = 0;     // long receiver stall request
   bit  tx_pause = 0;    // sender holds until drained

   function automatic logic [23:0] median5(logic [23:0] w [5]);
      logic [23:0] v [5];
      logic [23:0] t;
      for (int i = 0; i < 5; i++) v[i] = w[i];
      for (int i = 0; i < 5; i++)
         for (int j = 0; j < 4 - i; j++)
            if (v[j] > v[j+1]) begin
               t = v[j]; v[j] = v[j+1]; v[j+1] = t;
            end
      return v[2];
   endfunction

   // SystemVerilog '/' on signed longint truncates toward zero
   function automatic logic [21:0] trunc22(longint num, longint den);
      longint q;
      q = num / den;
      return q[21:0];
   endfunction

   task automatic predict_leads(sample_type s);
      longint d [3];
      leads_type r;
      win[0][slot] = s.c1; win[1][slot] = s.c2; win[2][slot] = s.c3;
      for (int c = 0; c < 3; c++) sums[c] += median5(win[c]);
      slot = (slot == 4) ? 0 : slot + 1;
      phase++;
      if (phase < 4) return;
      phase = 0;
      for (int c = 0; c < 3; c++) begin
         d[c] = 3 * (sums[c] - 25600000);
         sums[c] = 0;
      end
      if (s.alarm != 0) begin
         if (alarm_run < 16'hFFFF) alarm_run++;
      end else begin
         alarm_run = 0;
      end
      r.l1   = trunc22(d[0], 112);
      r.l2   = trunc22(d[1], 112);
      r.l2b  = trunc22(d[2], 112);
      r.l3   = trunc22(d[1] - d[0], 112);
      r.avr  = trunc22(-(d[0] + d[1]), 224);
      r.avl  = trunc22(2 * d[0] - d[1], 224);
      r.avf  = trunc22(2 * d[1] - d[0], 224);
      r.off  = s.off;
      r.off3 = s.off[2:0];
      r.fault = (alarm_run >= persist);
      r.seq  = seq_num;
      seq_num++;
      expected_leads.push_back(r);
   endtask

   // ---------------- driver ----------------
   int unsigned tx_gap = 0;
   initial begin
      req_chan.valid = 1'b0;
      req_chan.code_lead_one = '0; req_chan.code_lead_two_a = '0;
      req_chan.code_lead_two_b = '0; req_chan.electrode_off_bits = '0;
      req_chan.drive_alarm_bits = '0;
      rsp_chan.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_leads('{req_chan.code_lead_one, req_chan.code_lead_two_a,
                            req_chan.code_lead_two_b, req_chan.electrode_off_bits,
                            req_chan.drive_alarm_bits});
            tx_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0;
         end
         // present next word once gap elapses; keep valid high across back-to-back words
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (tx_gap > 0 || tx_pause || pending_words.size() == 0) begin
               if (tx_gap > 0) tx_gap--;
               req_chan.valid <= 1'b0;
            end else begin
               sample_type w;
               w = pending_words.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.code_lead_one      <= w.c1;
               req_chan.code_lead_two_a    <= w.c2;
               req_chan.code_lead_two_b    <= w.c3;
               req_chan.electrode_off_bits <= w.off;
               req_chan.drive_alarm_bits   <= w.alarm;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   int unsigned rx_gap = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_leads.size() == 0) begin
               $display("%0t: unexpected result word, sample %0d", $time,
                        rsp_chan.sample_number);
               errors++;
            end else begin
               leads_type e;
               e = expected_leads.pop_front();
               if (rsp_chan.lead_one_uv !== e.l1 || rsp_chan.lead_two_uv !== e.l2 ||
                   rsp_chan.lead_two_b_uv !== e.l2b || rsp_chan.lead_three_uv !== e.l3 ||
                   rsp_chan.augmented_right_uv !== e.avr ||
                   rsp_chan.augmented_left_uv !== e.avl ||
                   rsp_chan.augmented_foot_uv !== e.avf ||
                   rsp_chan.off_status !== e.off || rsp_chan.off_status_legacy !== e.off3 ||
                   rsp_chan.drive_fault !== e.fault || rsp_chan.sample_number !== e.seq) begin
                  $display("%0t: mismatch exp %0d %0d %0d %0d %0d %0d %0d %h %h %b %0d", $time,
                           e.l1, e.l2, e.l2b, e.l3, e.avr, e.avl, e.avf,
                           e.off, e.off3, e.fault, e.seq);
                  $display("%0t:          act %0d %0d %0d %0d %0d %0d %0d %h %h %b %0d", $time,
                           rsp_chan.lead_one_uv, rsp_chan.lead_two_uv, rsp_chan.lead_two_b_uv,
                           rsp_chan.lead_three_uv, rsp_chan.augmented_right_uv,
                           rsp_chan.augmented_left_uv, rsp_chan.augmented_foot_uv,
                           rsp_chan.off_status, rsp_chan.off_status_legacy,
                           rsp_chan.drive_fault, rsp_chan.sample_number);
                  errors++;
               end
            end
            rx_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0;
         end
         if (rx_hold) begin
            rsp_chan.ready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // timeout watchdog
   always @(posedge clock) begin
      if (cycles > 400000) begin
         $display("[ecg_median_decimate_leads] ERROR");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   function automatic logic [23:0] rand_code(int unsigned mode);
      case (mode)
         0: return 24'd0;
         1: return 24'hFFFFFF;
         2: return 24'(32'd6400000 + $urandom_range(0, 4000) - 32'd2000);
         default: return 24'($urandom_range(0, 24'hFFFFFF));
      endcase
   endfunction

   task automatic queue_word(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                             logic [3:0] off, logic [1:0] al);
      sample_word_push: pending_words.push_back('{a, b, c, off, al});
   endtask

   // sampled on the falling edge so the driver's updates have settled
   task automatic wait_drained();
      while (pending_words.size() != 0 || req_chan.valid || expected_leads.size() != 0)
         @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   // csr write while idle; also update the predictor's copy
   task automatic write_persist(logic [15:0] v);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      persist = v;
      @(posedge clock);
   endtask

   task automatic random_block(int n, int unsigned alarm_pct);
      logic [1:0] al;
      for (int i = 0; i < n; i++) begin
         al = ($urandom_range(0, 99) < alarm_pct) ? 2'($urandom_range(1, 3)) : 2'd0;
         queue_word(rand_code($urandom_range(0, 5)), rand_code($urandom_range(0, 5)),
                    rand_code($urandom_range(0, 5)), 4'($urandom_range(0, 15)), al);
      end
   endtask

   initial begin
      for (int c = 0; c < 3; c++) begin
         for (int k = 0; k < 5; k++) win[c][k] = CODE_ZERO;
         sums[c] = 0;
      end
      slot = 0; phase = 0; alarm_run = 0; seq_num = 0; persist = PERSIST_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: code extremes, median behavior, off bits, alarm run and reset
      for (int i = 0; i < 5; i++) queue_word(24'd0, 24'hFFFFFF, 24'd0, 4'hF, 2'd3);
      for (int i = 0; i < 5; i++) queue_word(24'hFFFFFF, 24'd0, 24'hFFFFFF, 4'h0, 2'd1);
      for (int i = 0; i < 6; i++) queue_word(24'd6400000, 24'd6400001, 24'd6399999,
                                             4'(i), 2'd2);
      for (int i = 0; i < 4; i++) queue_word(24'hFFFFFF, 24'hFFFFFF, 24'd0, 4'h8, 2'd0);
      wait_drained();

      // low thresholds with alarm-heavy traffic
      write_persist(16'd1);
      random_block(200, 90);
      wait_drained();
      write_persist(16'd0);   // zero threshold: fault always set
      random_block(100, 50);
      wait_drained();
      write_persist(16'd3);
      random_block(300, 70);

      // long receiver stall while sender keeps going, fills the queue
      wait (pending_words.size() < 280);
      rx_hold = 1;
      repeat (300) @(posedge clock);
      rx_hold = 0;

      // sender pause until drained
      tx_pause = 1;
      while (expected_leads.size() != 0) @(posedge clock);
      tx_pause = 0;
      wait_drained();

      write_persist(16'hFFFF);
      random_block(200, 95);
      wait_drained();
      write_persist(16'd2);
      random_block(280, 60);
      wait_drained();

      if (errors == 0) begin
         $display("[ecg_median_decimate_leads] OK");
      end else begin
         $display("[ecg_median_decimate_leads] ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
